// File: rtl/distance_triggered_pump_controller_macros.svh
`ifndef DISTANCE_TRIGGERED_PUMP_CONTROLLER_MACROS_SVH
`define DISTANCE_TRIGGERED_PUMP_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define DTPC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("dtpc assertion failed");
`define DTPC_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("dtpc forbidden condition seen");
`else
`define DTPC_ASSERT(lbl, clk, rstn, prop)
`define DTPC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: rtl/dtpc_pkg.sv
package dtpc_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_SPIN  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_INTERVAL     = 3'd0,
		REG_MIN_SPEED    = 3'd1,
		REG_TIMEOUT      = 3'd2,
		REG_STORED_TOTAL = 3'd3,
		REG_STORED_NEXT  = 3'd4
	} reg_idx_t;

	localparam logic [31:0] INTERVAL_RESET     = 32'd100000;
	localparam logic [15:0] MIN_SPEED_RESET    = 16'd0;
	localparam logic [15:0] TIMEOUT_RESET      = 16'd5;
	localparam logic [31:0] STORED_TOTAL_RESET = 32'd0;
	localparam logic [31:0] STORED_NEXT_RESET  = 32'd0;

	typedef struct packed {
		logic [31:0] distance_interval_mm;
		logic [15:0] minimal_speed_mm_s;
		logic [15:0] pump_timeout_s;
		logic [31:0] stored_total_mm;
		logic [31:0] stored_next_mm;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] trip_distance_mm;
		logic [15:0] speed_mm_s;
		logic        power_ok;
	} item_t;

	typedef struct packed {
		logic        pump_on;
		logic        lubricate_pending;
		logic        sleeping;
		logic [31:0] total_distance_mm;
		logic [31:0] next_distance_mm;
		logic        save_total;
		logic        save_next;
	} result_t;

	// saturating 32-bit add
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// File: rtl/dtpc_core.sv
`include "distance_triggered_pump_controller_macros.svh"

module dtpc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dtpc_pkg::item_t   item,
	input  dtpc_pkg::cfg_t    cfg,
	output dtpc_pkg::result_t result
);
	import dtpc_pkg::*;

	logic [31:0] saved_q, total_q, next_q;
	logic [31:0] saved_d, total_d, next_d;
	logic        flag_q, pump_q, asleep_q;
	logic        flag_d, pump_d, asleep_d;
	logic [15:0] cnt_q, cnt_d, cnt_dec;
	logic [31:0] trip_sum, start_next, tick_next;
	logic        save_total, save_next;

	assign trip_sum   = sat_add(saved_q, item.trip_distance_mm);
	assign start_next = sat_add(cfg.stored_total_mm, cfg.distance_interval_mm);
	// total_q holds saved total plus last trip, or just the saved total after a power loss
	assign tick_next  = sat_add(total_q, cfg.distance_interval_mm);
	assign cnt_dec    = (cnt_q != 16'd0) ? cnt_q - 16'd1 : 16'd0;

	always_comb begin
		saved_d    = saved_q;
		total_d    = total_q;
		next_d     = next_q;
		flag_d     = flag_q;
		pump_d     = pump_q;
		asleep_d   = asleep_q;
		cnt_d      = cnt_q;
		save_total = 1'b0;
		save_next  = 1'b0;
		case (item.command)
			CMD_START: begin
				saved_d  = cfg.stored_total_mm;
				total_d  = cfg.stored_total_mm;
				next_d   = cfg.stored_next_mm;
				if (cfg.stored_next_mm == 32'd0 ||
				    cfg.stored_next_mm <= cfg.stored_total_mm) begin
					next_d    = start_next;
					save_next = 1'b1;
				end
				pump_d   = 1'b0;
				cnt_d    = 16'd0;
				asleep_d = 1'b0;
			end
			CMD_SPIN: begin
				if (!asleep_q) begin
					total_d = trip_sum;
					if (!item.power_ok) begin
						saved_d    = trip_sum;
						save_total = 1'b1;
						pump_d     = 1'b0;
						cnt_d      = 16'd0;
						asleep_d   = 1'b1;
					end else begin
						if (trip_sum >= next_q)
							flag_d = 1'b1;
						if (item.speed_mm_s < cfg.minimal_speed_mm_s) begin
							pump_d = 1'b0;
							cnt_d  = 16'd0;
						end else if (flag_q && !pump_q) begin
							pump_d = 1'b1;
							cnt_d  = cfg.pump_timeout_s;
						end
					end
				end
			end
			CMD_TICK: begin
				if (!asleep_q && pump_q) begin
					if (cnt_dec == 16'd0) begin
						flag_d    = 1'b0;
						next_d    = tick_next;
						save_next = 1'b1;
						pump_d    = 1'b0;
					end
					cnt_d = cnt_dec;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q  <= 32'd0;
			total_q  <= 32'd0;
			next_q   <= 32'd0;
			flag_q   <= 1'b0;
			pump_q   <= 1'b0;
			asleep_q <= 1'b0;
			cnt_q    <= 16'd0;
		end else if (en) begin
			saved_q  <= saved_d;
			total_q  <= total_d;
			next_q   <= next_d;
			flag_q   <= flag_d;
			pump_q   <= pump_d;
			asleep_q <= asleep_d;
			cnt_q    <= cnt_d;
		end
	end

	assign result.pump_on           = pump_d;
	assign result.lubricate_pending = flag_d;
	assign result.sleeping          = asleep_d;
	assign result.total_distance_mm = total_d;
	assign result.next_distance_mm  = next_d;
	assign result.save_total        = save_total;
	assign result.save_next         = save_next;

	`DTPC_ASSERT(a_pump_needs_flag, clk, arst_n, pump_q |-> flag_q)
	`DTPC_ASSERT(a_sleep_pump_off, clk, arst_n, asleep_q |-> !pump_q)
	`DTPC_ASSERT(a_idle_timer_clear, clk, arst_n, !pump_q |-> (cnt_q == 16'd0))

endmodule

// File: rtl/distance_triggered_pump_controller.sv
// Distance-triggered lubrication pump controller. Commands arrive on the slave stream (start,
// spin with trip distance, speed and power state, one-second tick) and every transaction
// yields exactly one status transaction on the master stream. One transaction is taken per
// clock while the master stream is not stalled; an input register is followed by the state
// update and result register, whose state update loop sets the rate. The user must write
// settings and persisted distances through the APB port only while the stream is idle; the
// block does not enforce it. Distances are in millimetres and all sums saturate at 2^32-1.
`include "distance_triggered_pump_controller_macros.svh"

module distance_triggered_pump_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// trip_distance_mm[31:0], speed_mm_s[47:32], power_ok[48], zero pad
	input  logic [55:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pump_on[0], lubricate_pending[1], sleeping[2], total_distance_mm[34:3],
	// next_distance_mm[66:35], save_total[67], save_next[68], zero pad
	output logic [71:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dtpc_pkg::*;

	cfg_t     cfg_q;
	item_t    item_in, item_s1;
	logic     valid_s1, valid_s2;
	result_t  result_c, result_s2;
	logic     advance;
	logic     cfg_wr;
	reg_idx_t reg_idx;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance_interval_mm <= INTERVAL_RESET;
			cfg_q.minimal_speed_mm_s   <= MIN_SPEED_RESET;
			cfg_q.pump_timeout_s       <= TIMEOUT_RESET;
			cfg_q.stored_total_mm      <= STORED_TOTAL_RESET;
			cfg_q.stored_next_mm       <= STORED_NEXT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INTERVAL:     cfg_q.distance_interval_mm <= pwdata;
				REG_MIN_SPEED:    cfg_q.minimal_speed_mm_s   <= pwdata[15:0];
				REG_TIMEOUT:      cfg_q.pump_timeout_s       <= pwdata[15:0];
				REG_STORED_TOTAL: cfg_q.stored_total_mm      <= pwdata;
				REG_STORED_NEXT:  cfg_q.stored_next_mm       <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INTERVAL:     prdata = cfg_q.distance_interval_mm;
			REG_MIN_SPEED:    prdata = {16'd0, cfg_q.minimal_speed_mm_s};
			REG_TIMEOUT:      prdata = {16'd0, cfg_q.pump_timeout_s};
			REG_STORED_TOTAL: prdata = cfg_q.stored_total_mm;
			REG_STORED_NEXT:  prdata = cfg_q.stored_next_mm;
			default:          prdata = 32'd0;
		endcase
	end

	// input stage
	assign item_in.command          = cmd_t'(s_axis_tuser);
	assign item_in.trip_distance_mm = s_axis_tdata[31:0];
	assign item_in.speed_mm_s       = s_axis_tdata[47:32];
	assign item_in.power_ok         = s_axis_tdata[48];

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= item_in;
	end

	dtpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_c)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_axis_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result_c;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, result_s2.save_next, result_s2.save_total,
		result_s2.next_distance_mm, result_s2.total_distance_mm, result_s2.sleeping,
		result_s2.lubricate_pending, result_s2.pump_on};

	`DTPC_ASSERT(a_save_total_sleeps, clk, arst_n, (valid_s2 && result_s2.save_total) |-> result_s2.sleeping)
	`DTPC_ASSERT_NEVER(a_both_saves, clk, arst_n, valid_s2 && result_s2.save_total && result_s2.save_next)
	`DTPC_ASSERT(a_ready_when_empty, clk, arst_n, !valid_s2 |-> s_axis_tready)

endmodule

// File: test/distance_triggered_pump_controller_tb.sv
`timescale 1ns / 100ps

module distance_triggered_pump_controller_tb;
	import dtpc_pkg::*;

	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam logic [31:0] DIST_MAX    = 32'hFFFF_FFFF;
	localparam int          STALL_LIMIT = 4000;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] trip;
		logic [15:0] speed;
		logic        power;
	} cmd_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// trip_distance_mm[31:0], speed_mm_s[47:32], power_ok[48], zero pad
	logic [55:0] s_axis_tdata;
	// command[1:0]
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// pump_on[0], lubricate_pending[1], sleeping[2], total_distance_mm[34:3],
	// next_distance_mm[66:35], save_total[67], save_next[68], zero pad
	logic [71:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	distance_triggered_pump_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	// settings as last written over apb
	cfg_t cfg;

	// controller state mirror
	logic [31:0] ctl_total;
	logic [31:0] ctl_next;
	logic [31:0] ctl_trip;
	logic        ctl_flag;
	logic        ctl_pump;
	logic        ctl_timer_on;
	logic [15:0] ctl_count;
	logic        ctl_asleep;

	cmd_word_t pending_cmds[$];
	result_t   expected_status[$];
	cmd_word_t on_bus;
	result_t   seen;
	result_t   want;

	bit calm;
	int gap_left;
	int stall_left;
	int quiet_cycles;
	int mismatches;
	int n_checked;
	int n_phases;
	int pump_starts;
	int run_ends;
	int power_losses;

	function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] wide;
		wide = {1'b0, a} + {1'b0, b};
		if (wide > {1'b0, DIST_MAX})
			return DIST_MAX;
		return wide[31:0];
	endfunction

	function automatic void halt_pump();
		ctl_pump     = 1'b0;
		ctl_timer_on = 1'b0;
		ctl_count    = '0;
	endfunction

	function automatic result_t advance_controller(input cmd_word_t c);
		result_t r;
		logic    was_pending;
		r = '0;
		if (c.op == CMD_START) begin
			ctl_total = cfg.stored_total_mm;
			ctl_trip  = '0;
			ctl_next  = cfg.stored_next_mm;
			if (ctl_next == 0 || ctl_next <= ctl_total) begin
				ctl_next    = clamp_sum(ctl_total, cfg.distance_interval_mm);
				r.save_next = 1'b1;
			end
			halt_pump();
			ctl_asleep = 1'b0;
		end else if (c.op == CMD_SPIN && !ctl_asleep) begin
			if (!c.power) begin
				ctl_total    = clamp_sum(ctl_total, c.trip);
				ctl_trip     = '0;
				r.save_total = 1'b1;
				halt_pump();
				ctl_asleep = 1'b1;
				power_losses++;
			end else begin
				was_pending = ctl_flag;
				ctl_trip    = c.trip;
				if (clamp_sum(ctl_total, c.trip) >= ctl_next)
					ctl_flag = 1'b1;
				if (c.speed < cfg.minimal_speed_mm_s) begin
					halt_pump();
				end else if (was_pending && !ctl_pump) begin
					ctl_pump     = 1'b1;
					ctl_timer_on = 1'b1;
					ctl_count    = cfg.pump_timeout_s;
					pump_starts++;
				end
			end
		end else if (c.op == CMD_TICK && !ctl_asleep && ctl_timer_on) begin
			if (ctl_count != 0)
				ctl_count--;
			if (ctl_count == 0) begin
				ctl_flag    = 1'b0;
				ctl_next    = clamp_sum(clamp_sum(ctl_total, ctl_trip),
					cfg.distance_interval_mm);
				r.save_next = 1'b1;
				halt_pump();
				run_ends++;
			end
		end
		r.pump_on           = ctl_pump;
		r.lubricate_pending = ctl_flag;
		r.sleeping          = ctl_asleep;
		r.total_distance_mm = clamp_sum(ctl_total, ctl_trip);
		r.next_distance_mm  = ctl_next;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// stimulus side
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= CMD_START;
			gap_left      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_status.push_back(advance_controller(on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					s_axis_tvalid <= 1'b0;
					gap_left      <= gap_left - 1;
				end else if (pending_cmds.size() > 0) begin
					on_bus = pending_cmds.pop_front();
					s_axis_tdata  <= {7'b0, on_bus.power, on_bus.speed, on_bus.trip};
					s_axis_tuser  <= on_bus.op;
					s_axis_tvalid <= 1'b1;
					gap_left      <= (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.pump_on           = m_axis_tdata[0];
				seen.lubricate_pending = m_axis_tdata[1];
				seen.sleeping          = m_axis_tdata[2];
				seen.total_distance_mm = m_axis_tdata[34:3];
				seen.next_distance_mm  = m_axis_tdata[66:35];
				seen.save_total        = m_axis_tdata[67];
				seen.save_next         = m_axis_tdata[68];
				if (expected_status.size() == 0) begin
					$display("%0t: status transaction with none expected, actual %0h",
						$time, m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("pump_on", 32'(want.pump_on), 32'(seen.pump_on));
					check_field("lubricate_pending", 32'(want.lubricate_pending),
						32'(seen.lubricate_pending));
					check_field("sleeping", 32'(want.sleeping), 32'(seen.sleeping));
					check_field("total_distance_mm", want.total_distance_mm,
						seen.total_distance_mm);
					check_field("next_distance_mm", want.next_distance_mm,
						seen.next_distance_mm);
					check_field("save_total", 32'(want.save_total), 32'(seen.save_total));
					check_field("save_next", 32'(want.save_next), 32'(seen.save_next));
				end
				n_checked++;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left    <= pick_gap() - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_cmd(input logic [1:0] op, input logic [31:0] trip,
		input logic [15:0] speed, input logic power);
		cmd_word_t c;
		c.op    = op;
		c.trip  = trip;
		c.speed = speed;
		c.power = power;
		pending_cmds.push_back(c);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_INTERVAL:     cfg.distance_interval_mm = val;
			REG_MIN_SPEED:    cfg.minimal_speed_mm_s   = val[15:0];
			REG_TIMEOUT:      cfg.pump_timeout_s       = val[15:0];
			REG_STORED_TOTAL: cfg.stored_total_mm      = val;
			REG_STORED_NEXT:  cfg.stored_next_mm       = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [31:0] interval, input logic [15:0] min_speed,
		input logic [15:0] timeout, input logic [31:0] s_total, input logic [31:0] s_next);
		write_reg(REG_INTERVAL, interval);
		write_reg(REG_MIN_SPEED, {16'b0, min_speed});
		write_reg(REG_TIMEOUT, {16'b0, timeout});
		write_reg(REG_STORED_TOTAL, s_total);
		write_reg(REG_STORED_NEXT, s_next);
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
		repeat (4) @(negedge clk);
		n_phases++;
	endtask

	// start, then mostly forward driving with ticks, some power cuts and noise
	task automatic queue_run(input int n);
		int          counted;
		int          r;
		logic [31:0] trip;
		logic [31:0] step;
		logic [15:0] speed;
		bit          dozing;
		trip    = '0;
		dozing  = 1'b0;
		counted = 0;
		push_cmd(CMD_START, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
		while (counted < n) begin
			r = $urandom_range(0, 99);
			step = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 4000);
			trip = (trip > DIST_MAX - step) ? DIST_MAX : trip + step;
			if (cfg.minimal_speed_mm_s != 0 && $urandom_range(0, 6) == 0)
				speed = 16'($urandom_range(0, cfg.minimal_speed_mm_s - 1));
			else
				speed = 16'($urandom_range(cfg.minimal_speed_mm_s, 16'hFFFF));
			if (dozing) begin
				if (r < 40) begin
					push_cmd((r < 20) ? CMD_SPIN : CMD_TICK, $urandom, 16'($urandom),
						1'($urandom_range(0, 1)));
				end else begin
					push_cmd(CMD_START, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
					trip    = '0;
					dozing  = 1'b0;
					counted++;
				end
			end else begin
				counted++;
				if (r < 50) begin
					push_cmd(CMD_SPIN, trip, speed, 1'b1);
				end else if (r < 82) begin
					push_cmd(CMD_TICK, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
				end else if (r < 87) begin
					push_cmd(CMD_START, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
					trip = '0;
				end else if (r < 90) begin
					push_cmd(CMD_SPIN, trip, speed, 1'b0);
					dozing = 1'b1;
				end else if (r < 93) begin
					push_cmd(CMD_UNUSED, $urandom, 16'($urandom), 1'($urandom_range(0, 1)));
				end else begin
					push_cmd(CMD_SPIN, $urandom, 16'($urandom), 1'b1);
				end
			end
		end
	endtask

	initial begin
		logic [31:0] interval;
		logic [15:0] min_speed;
		logic [15:0] timeout;
		logic [31:0] s_total;
		logic [31:0] s_next;
		int          r;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_START;
		m_axis_tready = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		calm          = 1'b0;
		mismatches    = 0;
		n_checked     = 0;
		n_phases      = 0;
		pump_starts   = 0;
		run_ends      = 0;
		power_losses  = 0;
		cfg.distance_interval_mm = INTERVAL_RESET;
		cfg.minimal_speed_mm_s   = MIN_SPEED_RESET;
		cfg.pump_timeout_s       = TIMEOUT_RESET;
		cfg.stored_total_mm      = STORED_TOTAL_RESET;
		cfg.stored_next_mm       = STORED_NEXT_RESET;
		ctl_total    = '0;
		ctl_next     = '0;
		ctl_trip     = '0;
		ctl_flag     = 1'b0;
		ctl_asleep   = 1'b0;
		halt_pump();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: spin before any start, idle tick, unused code, full run and expiry
		push_cmd(CMD_SPIN, 32'd0, 16'd0, 1'b1);
		push_cmd(CMD_TICK, 32'd0, 16'd0, 1'b1);
		push_cmd(CMD_UNUSED, DIST_MAX, 16'hFFFF, 1'b1);
		push_cmd(CMD_START, 32'd0, 16'd0, 1'b0);
		push_cmd(CMD_SPIN, 32'd50000, 16'd100, 1'b1);
		push_cmd(CMD_SPIN, 32'd100000, 16'hFFFF, 1'b1);
		push_cmd(CMD_SPIN, 32'd120000, 16'd1, 1'b1);
		repeat (5) push_cmd(CMD_TICK, 32'd0, 16'd0, 1'b0);
		// saturating trip, then power cut and ignored traffic while asleep
		push_cmd(CMD_SPIN, DIST_MAX, 16'd0, 1'b1);
		push_cmd(CMD_SPIN, DIST_MAX, 16'd0, 1'b0);
		push_cmd(CMD_SPIN, 32'd10, 16'd10, 1'b1);
		push_cmd(CMD_TICK, 32'd0, 16'd0, 1'b1);
		push_cmd(CMD_START, 32'd0, 16'd0, 1'b1);
		drain();

		// stored next already passed, speed threshold, zero timeout
		set_all(32'd2500, 16'd1000, 16'd0, 32'd5000, 32'd3000);
		push_cmd(CMD_START, 32'd0, 16'd0, 1'b1);
		push_cmd(CMD_SPIN, 32'd100, 16'd999, 1'b1);
		push_cmd(CMD_SPIN, 32'd200, 16'd1000, 1'b1);
		push_cmd(CMD_TICK, 32'd0, 16'd0, 1'b1);
		push_cmd(CMD_SPIN, 32'd2700, 16'hFFFF, 1'b1);
		push_cmd(CMD_TICK, 32'd0, 16'd0, 1'b1);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p == 0) begin
				set_all(32'd0, 16'd0, 16'd0, 32'd0, 32'd0);
			end else if (p == 1) begin
				set_all(DIST_MAX, 16'hFFFF, 16'hFFFF, DIST_MAX, DIST_MAX);
			end else begin
				r = $urandom_range(0, 9);
				interval = (r == 0) ? 32'd0 : (r == 1) ? DIST_MAX : $urandom_range(1, 20000);
				r = $urandom_range(0, 9);
				min_speed = (r < 4) ? 16'd0 : (r == 4) ? 16'hFFFF :
					16'($urandom_range(1, 3000));
				r = $urandom_range(0, 9);
				timeout = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 6));
				r = $urandom_range(0, 9);
				s_total = (r == 0) ? 32'd0 : (r == 1) ? DIST_MAX - $urandom_range(0, 30000) :
					(r == 2) ? $urandom : $urandom_range(0, 100000);
				r = $urandom_range(0, 9);
				if (r == 0)
					s_next = 32'd0;
				else if (r == 1)
					s_next = DIST_MAX;
				else if (r == 2)
					s_next = $urandom;
				else
					s_next = clamp_sum(s_total, $urandom_range(0, 20000));
				set_all(interval, min_speed, timeout, s_total, s_next);
			end
			calm = (p % 4 == 3);
			queue_run(100);
			drain();
		end

		$display("summary: %0d status transactions checked across %0d setting phases",
			n_checked, n_phases);
		$display("summary: %0d pump runs started, %0d runs ended, %0d power cuts",
			pump_starts, run_ends, power_losses);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
